FILE: hdl/bfia_pkg.sv
// Shared types and constants for the best-fit interval allocator.
// Holds operation codes, status codes, controller states and parameter defaults.
// No dependencies.
`default_nettype none

package bfia_pkg;

    // Parameter defaults.
    localparam int NUM_PROGRAMS_DEF     = 16;
    localparam int MAX_SEGMENTS_DEF     = 16;
    localparam int MAX_FREE_REGIONS_DEF = 64;
    localparam int ADDR_BITS_DEF        = 32;

    // Fixed field widths.
    localparam int OP_W     = 2;
    localparam int PROG_W   = 4;
    localparam int LEN_W    = 32;
    localparam int IDX_W    = 5;
    localparam int VALUE_W  = 37;
    localparam int STATUS_W = 2;

    // Operation codes. The last code is unassigned and is rejected.
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_SEND    = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FIT    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd3;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_ALLOC_WR,
        ST_SEND_RD,
        ST_SEND_WR,
        ST_REL_RD,
        ST_REL_LOAD,
        ST_SHIFT_CHK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_REL_FREE,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

FILE: hdl/best_fit_interval_allocator_top.sv
// Best-fit interval allocator: free-region table, per-program segment lists.
// Two synchronous memories (free regions, segments) with a read-modify-write controller.
// Depends on bfia_pkg.
//
// Usage: one input beat (operation, program_req, length, segment_index) yields one
// output beat (value, status). Both channels use valid/stall; a beat moves on an edge
// with valid high and stall low. The block works on one operation at a time and
// holds in_stall high from acceptance until the result has entered the output register.
// The time from acceptance to out_valid is set by the scan over the free-region memory
// (one entry per cycle) and by the segment walk (a read and a write state per segment
// summed; a check, a read and a write state per segment moved). An allocation scans
// the whole table unless it is rejected before the scan; a send walks every segment of
// the program; a release, unless its index is bad, scans the table and, if the table
// has room, moves each segment behind the released one. The next beat can be accepted
// in the cycle after the result is loaded.
// Reset leaves one free region covering the whole address space and all segment lists
// empty; no clearing pass is needed. The output register keeps its beat while out_stall
// is high; the next operation can be accepted and worked on meanwhile, and it waits
// in its final state until the output register frees up.
`default_nettype none

module best_fit_interval_allocator_top #(
    parameter int NUM_PROGRAMS     = bfia_pkg::NUM_PROGRAMS_DEF,
    parameter int MAX_SEGMENTS     = bfia_pkg::MAX_SEGMENTS_DEF,
    parameter int MAX_FREE_REGIONS = bfia_pkg::MAX_FREE_REGIONS_DEF,
    parameter int ADDR_BITS        = bfia_pkg::ADDR_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [bfia_pkg::OP_W-1:0]      operation,
    input  wire logic [bfia_pkg::PROG_W-1:0]    program_req,
    input  wire logic [bfia_pkg::LEN_W-1:0]     length,
    input  wire logic [bfia_pkg::IDX_W-1:0]     segment_index,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [bfia_pkg::VALUE_W-1:0]        value,
    output logic [bfia_pkg::STATUS_W-1:0]       status
);

    localparam int AW     = ADDR_BITS;
    localparam int LW     = bfia_pkg::LEN_W;
    localparam int VW     = bfia_pkg::VALUE_W;
    localparam int FW     = $clog2(MAX_FREE_REGIONS);
    localparam int CW     = $clog2(MAX_SEGMENTS + 1);
    localparam int PW     = (NUM_PROGRAMS > 1) ? $clog2(NUM_PROGRAMS) : 1;
    localparam int SDEPTH = NUM_PROGRAMS * MAX_SEGMENTS;
    localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int CMPW   = (AW + 1 > LW + 1) ? AW + 1 : LW + 1;
    localparam logic [AW-1:0] TOP_ADDR  = {AW{1'b1}};
    localparam logic [FW-1:0] LAST_FREE = FW'(MAX_FREE_REGIONS - 1);

    // Memories.
    logic [AW-1:0] free_start_mem [MAX_FREE_REGIONS];
    logic [AW-1:0] free_end_mem   [MAX_FREE_REGIONS];
    logic [AW-1:0] seg_start_mem  [SDEPTH];
    logic [LW-1:0] seg_len_mem    [SDEPTH];
    logic [LW-1:0] seg_off_mem    [SDEPTH];

    // Control state.
    bfia_pkg::state_t state_reg, state_next;
    logic [CW-1:0] seg_count_reg [NUM_PROGRAMS];
    logic [MAX_FREE_REGIONS-1:0] free_valid_reg;
    logic e0_written_reg;
    logic pend_reg;
    logic out_valid_reg;

    // Operation registers.
    logic [bfia_pkg::OP_W-1:0]  op_reg;
    logic [PW-1:0]              prog_reg;
    logic                       prog_bad_reg;
    logic [LW-1:0]              len_reg;
    logic [bfia_pkg::IDX_W-1:0] idx_reg;

    // Scan and walk registers.
    logic [FW-1:0] scan_idx_reg, pend_idx_reg;
    logic          best_found_reg;
    logic [FW-1:0] best_idx_reg;
    logic [AW-1:0] best_start_reg, best_end_reg;
    logic [CMPW-1:0] best_len_reg;
    logic          above_found_reg, below_found_reg, empty_found_reg;
    logic [FW-1:0] above_idx_reg, below_idx_reg, empty_idx_reg;
    logic [AW-1:0] above_end_reg, below_start_reg;
    logic [AW-1:0] lo_reg, hi_reg;
    logic [CW-1:0] k_reg;
    logic [VW-1:0] sum_reg;
    logic [VW-1:0] res_value_reg;
    logic [bfia_pkg::STATUS_W-1:0] res_status_reg;
    logic [VW-1:0] value_reg;
    logic [bfia_pkg::STATUS_W-1:0] status_reg;

    // Memory read data.
    logic [AW-1:0] free_rd_start_reg, free_rd_end_reg;
    logic [AW-1:0] seg_rd_start_reg;
    logic [LW-1:0] seg_rd_len_reg, seg_rd_off_reg;

    // Memory ports.
    logic          free_we;
    logic [FW-1:0] free_waddr;
    logic [AW-1:0] free_wstart, free_wend;
    logic          seg_we;
    logic [SAW-1:0] seg_raddr, seg_waddr;
    logic [AW-1:0] seg_wstart;
    logic [LW-1:0] seg_wlen, seg_woff;

    // Datapath helpers.
    logic          in_acc;
    logic          scan_start;
    logic          out_load;
    logic [CW-1:0] cnt_cur;
    logic          e_valid;
    logic [AW-1:0] e_start, e_end;
    logic [CMPW-1:0] e_len;
    logic          e_fits, e_better, above_hit, below_hit;
    logic          split;
    logic [VW-1:0] send_term;
    logic [VW-1:0] sum_next;
    logic [LW-1:0] off_next;
    logic [63:0]   send_wide;
    logic [63:0]   best_wide;

    function automatic logic [SAW-1:0] seg_addr(input logic [PW-1:0] p, input logic [CW-1:0] s);
        int a;
        a = int'(p) * MAX_SEGMENTS + int'(s);
        return SAW'(a);
    endfunction

    assign in_stall  = (state_reg != bfia_pkg::ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;
    assign cnt_cur   = seg_count_reg[prog_reg];
    assign out_load  = (state_reg == bfia_pkg::ST_FIN) && (!out_valid_reg || !out_stall);

    // Free-table entry under evaluation; entry zero reads as the whole space until written.
    always_comb
    begin
        e_valid = free_valid_reg[pend_idx_reg];
        if (pend_idx_reg == '0 && !e0_written_reg)
        begin
            e_start = '0;
            e_end   = TOP_ADDR;
        end
        else
        begin
            e_start = free_rd_start_reg;
            e_end   = free_rd_end_reg;
        end
        e_len     = CMPW'(e_end) - CMPW'(e_start) + CMPW'(1);
        e_fits    = e_valid && (e_len >= CMPW'(len_reg));
        e_better  = !best_found_reg || (e_len < best_len_reg) ||
                    ((e_len == best_len_reg) && (e_start < best_start_reg));
        above_hit = e_valid && (hi_reg != TOP_ADDR) && (e_start == AW'(hi_reg + AW'(1)));
        below_hit = e_valid && (lo_reg != '0) && (e_end == AW'(lo_reg - AW'(1)));
    end

    // Send accumulation and offset advance.
    always_comb
    begin
        send_wide = 64'(seg_rd_start_reg) + 64'(seg_rd_off_reg);
        send_term = send_wide[VW-1:0];
        sum_next  = sum_reg + send_term;
        if ((33'(seg_rd_off_reg) + 33'd1) == 33'(seg_rd_len_reg))
            off_next = '0;
        else
            off_next = seg_rd_off_reg + LW'(1);
        split     = best_len_reg > CMPW'(len_reg);
        best_wide = 64'(best_start_reg);
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bfia_pkg::ST_IDLE:
                if (in_acc)
                    state_next = bfia_pkg::ST_DECODE;
            bfia_pkg::ST_DECODE:
                if (prog_bad_reg)
                    state_next = bfia_pkg::ST_FIN;
                else
                begin
                    unique case (op_reg)
                        bfia_pkg::OP_ALLOC:
                            if (len_reg == '0 || 32'(cnt_cur) >= MAX_SEGMENTS)
                                state_next = bfia_pkg::ST_FIN;
                            else
                                state_next = bfia_pkg::ST_SCAN;
                        bfia_pkg::OP_SEND:
                            if (cnt_cur == '0)
                                state_next = bfia_pkg::ST_FIN;
                            else
                                state_next = bfia_pkg::ST_SEND_RD;
                        bfia_pkg::OP_RELEASE:
                            if (idx_reg == '0 || 32'(idx_reg) > 32'(cnt_cur))
                                state_next = bfia_pkg::ST_FIN;
                            else
                                state_next = bfia_pkg::ST_REL_RD;
                        default:
                            state_next = bfia_pkg::ST_FIN;
                    endcase
                end
            bfia_pkg::ST_SCAN:
                if (scan_idx_reg == LAST_FREE)
                    state_next = bfia_pkg::ST_DRAIN;
            bfia_pkg::ST_DRAIN:
                state_next = bfia_pkg::ST_DECIDE;
            bfia_pkg::ST_DECIDE:
                if (op_reg == bfia_pkg::OP_ALLOC)
                    state_next = best_found_reg ? bfia_pkg::ST_ALLOC_WR : bfia_pkg::ST_FIN;
                else if (above_found_reg || below_found_reg || empty_found_reg)
                    state_next = bfia_pkg::ST_SHIFT_CHK;
                else
                    state_next = bfia_pkg::ST_FIN;
            bfia_pkg::ST_ALLOC_WR:
                state_next = bfia_pkg::ST_FIN;
            bfia_pkg::ST_SEND_RD:
                state_next = bfia_pkg::ST_SEND_WR;
            bfia_pkg::ST_SEND_WR:
                if (32'(k_reg) + 1 >= 32'(cnt_cur))
                    state_next = bfia_pkg::ST_FIN;
                else
                    state_next = bfia_pkg::ST_SEND_RD;
            bfia_pkg::ST_REL_RD:
                state_next = bfia_pkg::ST_REL_LOAD;
            bfia_pkg::ST_REL_LOAD:
                state_next = bfia_pkg::ST_SCAN;
            bfia_pkg::ST_SHIFT_CHK:
                if (32'(k_reg) + 1 < 32'(cnt_cur))
                    state_next = bfia_pkg::ST_SHIFT_RD;
                else
                    state_next = bfia_pkg::ST_REL_FREE;
            bfia_pkg::ST_SHIFT_RD:
                state_next = bfia_pkg::ST_SHIFT_WR;
            bfia_pkg::ST_SHIFT_WR:
                state_next = bfia_pkg::ST_SHIFT_CHK;
            bfia_pkg::ST_REL_FREE:
                state_next = bfia_pkg::ST_FIN;
            bfia_pkg::ST_FIN:
                if (out_load)
                    state_next = bfia_pkg::ST_IDLE;
            default:
                state_next = bfia_pkg::ST_IDLE;
        endcase
    end

    // Memory port control.
    always_comb
    begin
        scan_start  = 1'b0;
        free_we     = 1'b0;
        free_waddr  = best_idx_reg;
        free_wstart = AW'(CMPW'(best_start_reg) + CMPW'(len_reg));
        free_wend   = best_end_reg;
        seg_we      = 1'b0;
        seg_raddr   = seg_addr(prog_reg, k_reg);
        seg_waddr   = seg_addr(prog_reg, k_reg);
        seg_wstart  = seg_rd_start_reg;
        seg_wlen    = seg_rd_len_reg;
        seg_woff    = off_next;
        unique case (state_reg)
            bfia_pkg::ST_DECODE:
                scan_start = (op_reg == bfia_pkg::OP_ALLOC);
            bfia_pkg::ST_REL_LOAD:
                scan_start = 1'b1;
            bfia_pkg::ST_ALLOC_WR:
            begin
                seg_we     = 1'b1;
                seg_waddr  = seg_addr(prog_reg, cnt_cur);
                seg_wstart = best_start_reg;
                seg_wlen   = len_reg;
                seg_woff   = '0;
                free_we    = split;
            end
            bfia_pkg::ST_SEND_WR:
                seg_we = 1'b1;
            bfia_pkg::ST_SHIFT_RD:
                seg_raddr = seg_addr(prog_reg, CW'(k_reg + CW'(1)));
            bfia_pkg::ST_SHIFT_WR:
            begin
                seg_we   = 1'b1;
                seg_woff = seg_rd_off_reg;
            end
            bfia_pkg::ST_REL_FREE:
            begin
                free_we = 1'b1;
                if (above_found_reg && below_found_reg)
                begin
                    free_waddr  = below_idx_reg;
                    free_wstart = below_start_reg;
                    free_wend   = above_end_reg;
                end
                else if (above_found_reg)
                begin
                    free_waddr  = above_idx_reg;
                    free_wstart = lo_reg;
                    free_wend   = above_end_reg;
                end
                else if (below_found_reg)
                begin
                    free_waddr  = below_idx_reg;
                    free_wstart = below_start_reg;
                    free_wend   = hi_reg;
                end
                else
                begin
                    free_waddr  = empty_idx_reg;
                    free_wstart = lo_reg;
                    free_wend   = hi_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Free-region memory.
    always_ff @(posedge clk)
    begin
        if (free_we)
        begin
            free_start_mem[free_waddr] <= free_wstart;
            free_end_mem[free_waddr]   <= free_wend;
        end
        free_rd_start_reg <= free_start_mem[scan_idx_reg];
        free_rd_end_reg   <= free_end_mem[scan_idx_reg];
    end

    // Segment memory.
    always_ff @(posedge clk)
    begin
        if (seg_we)
        begin
            seg_start_mem[seg_waddr] <= seg_wstart;
            seg_len_mem[seg_waddr]   <= seg_wlen;
            seg_off_mem[seg_waddr]   <= seg_woff;
        end
        seg_rd_start_reg <= seg_start_mem[seg_raddr];
        seg_rd_len_reg   <= seg_len_mem[seg_raddr];
        seg_rd_off_reg   <= seg_off_mem[seg_raddr];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bfia_pkg::ST_IDLE;
            free_valid_reg <= MAX_FREE_REGIONS'(1);
            e0_written_reg <= 1'b0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_PROGRAMS; i++)
                seg_count_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= (state_reg == bfia_pkg::ST_SCAN);
            if (free_we && free_waddr == '0)
                e0_written_reg <= 1'b1;
            if (state_reg == bfia_pkg::ST_ALLOC_WR)
            begin
                seg_count_reg[prog_reg] <= cnt_cur + CW'(1);
                if (!split)
                    free_valid_reg[best_idx_reg] <= 1'b0;
            end
            if (state_reg == bfia_pkg::ST_REL_FREE)
            begin
                seg_count_reg[prog_reg] <= cnt_cur - CW'(1);
                if (above_found_reg && below_found_reg)
                    free_valid_reg[above_idx_reg] <= 1'b0;
                else if (!above_found_reg && !below_found_reg)
                    free_valid_reg[empty_idx_reg] <= 1'b1;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Operation and datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg       <= operation;
            prog_reg     <= PW'(32'(program_req));
            prog_bad_reg <= 32'(program_req) >= NUM_PROGRAMS;
            len_reg      <= length;
            idx_reg      <= segment_index;
        end

        // Early results and walk setup; a release walk starts at the released entry.
        if (state_reg == bfia_pkg::ST_DECODE)
        begin
            res_value_reg <= '0;
            sum_reg       <= '0;
            if (!prog_bad_reg && op_reg == bfia_pkg::OP_RELEASE)
                k_reg <= CW'(32'(idx_reg) - 1);
            else
                k_reg <= '0;
            if (prog_bad_reg)
                res_status_reg <= bfia_pkg::STATUS_BAD_INDEX;
            else
            begin
                unique case (op_reg)
                    bfia_pkg::OP_ALLOC:
                        if (len_reg == '0)
                            res_status_reg <= bfia_pkg::STATUS_NO_FIT;
                        else
                            res_status_reg <= bfia_pkg::STATUS_FULL;
                    bfia_pkg::OP_SEND:
                        res_status_reg <= bfia_pkg::STATUS_OK;
                    bfia_pkg::OP_RELEASE:
                        res_status_reg <= bfia_pkg::STATUS_BAD_INDEX;
                    default:
                        res_status_reg <= bfia_pkg::STATUS_BAD_INDEX;
                endcase
            end
        end

        // Free-table scan.
        if (scan_start)
        begin
            scan_idx_reg    <= '0;
            best_found_reg  <= 1'b0;
            above_found_reg <= 1'b0;
            below_found_reg <= 1'b0;
            empty_found_reg <= 1'b0;
        end
        else if (state_reg == bfia_pkg::ST_SCAN)
            scan_idx_reg <= scan_idx_reg + FW'(1);
        pend_idx_reg <= scan_idx_reg;
        if (pend_reg)
        begin
            if (op_reg == bfia_pkg::OP_ALLOC)
            begin
                if (e_fits && e_better)
                begin
                    best_found_reg <= 1'b1;
                    best_idx_reg   <= pend_idx_reg;
                    best_start_reg <= e_start;
                    best_end_reg   <= e_end;
                    best_len_reg   <= e_len;
                end
            end
            else
            begin
                if (!e_valid && !empty_found_reg)
                begin
                    empty_found_reg <= 1'b1;
                    empty_idx_reg   <= pend_idx_reg;
                end
                if (above_hit)
                begin
                    above_found_reg <= 1'b1;
                    above_idx_reg   <= pend_idx_reg;
                    above_end_reg   <= e_end;
                end
                if (below_hit)
                begin
                    below_found_reg <= 1'b1;
                    below_idx_reg   <= pend_idx_reg;
                    below_start_reg <= e_start;
                end
            end
        end

        // Outcome of the scan.
        if (state_reg == bfia_pkg::ST_DECIDE)
        begin
            if (op_reg == bfia_pkg::OP_ALLOC)
                res_status_reg <= bfia_pkg::STATUS_NO_FIT;
            else
                res_status_reg <= bfia_pkg::STATUS_FULL;
        end
        if (state_reg == bfia_pkg::ST_ALLOC_WR)
        begin
            res_value_reg  <= best_wide[VW-1:0];
            res_status_reg <= bfia_pkg::STATUS_OK;
        end

        // Release target bounds.
        if (state_reg == bfia_pkg::ST_REL_LOAD)
        begin
            lo_reg <= seg_rd_start_reg;
            hi_reg <= AW'(CMPW'(seg_rd_start_reg) + CMPW'(seg_rd_len_reg) - CMPW'(1));
        end

        // Segment walks.
        if (state_reg == bfia_pkg::ST_SEND_WR)
        begin
            sum_reg       <= sum_next;
            res_value_reg <= sum_next;
            k_reg         <= k_reg + CW'(1);
        end
        if (state_reg == bfia_pkg::ST_SHIFT_WR)
            k_reg <= k_reg + CW'(1);
        if (state_reg == bfia_pkg::ST_REL_FREE)
            res_status_reg <= bfia_pkg::STATUS_OK;

        // Output register.
        if (out_load)
        begin
            value_reg  <= res_value_reg;
            status_reg <= res_status_reg;
        end
    end

    // Checks on the controller.
    a_alloc_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bfia_pkg::ST_ALLOC_WR |-> 32'(cnt_cur) < MAX_SEGMENTS)
        else $error("allocation write with a full segment list");

    a_release_slot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bfia_pkg::ST_REL_FREE |->
            (above_found_reg || below_found_reg || empty_found_reg))
        else $error("release update without a free-table slot");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == bfia_pkg::ST_FIN))
        else $error("output beat raised outside the final state");

    a_scan_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bfia_pkg::ST_SCAN |=> pend_reg)
        else $error("scan read not marked pending");

endmodule

`default_nettype wire
